FILE: hdl/cma_pkg.sv
// ----------------------------------------------------------------------------
// Centered moving average package
// Sizes, the reciprocal used for the division by the window length, and the
// types that are shared between the modules of the filter.
// ----------------------------------------------------------------------------
package cma_pkg;

  // Window length and sample width.
  localparam int WINDOW      = 25;
  localparam int SAMPLE_BITS = 16;

  // Samples that must follow position i before its output is known.
  localparam int LEAD = WINDOW - 1 - WINDOW / 2;

  // Running sum width: enough for WINDOW full-scale samples.
  localparam int WIN_LOG   = $clog2(WINDOW);
  localparam int SUM_BITS  = SAMPLE_BITS + WIN_LOG;
  localparam int SEEN_BITS = $clog2(LEAD + 2);
  localparam int FLUSH_BITS = $clog2(LEAD + 1);

  // Division by WINDOW as a multiply by a rounded-up reciprocal. With the
  // shift set to SUM_BITS + ceil(log2(WINDOW)), the quotient is exact for
  // any dividend that fits in SUM_BITS unsigned bits.
  localparam int DIV_SHIFT  = SUM_BITS + WIN_LOG;
  localparam int RECIP_BITS = SUM_BITS + 1;
  localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(
      ((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam logic [SUM_BITS-1:0] HALF_WINDOW = SUM_BITS'(WINDOW / 2);

  // Sequence control states.
  typedef enum logic [0:0] {
    ST_RUN,
    ST_FLUSH
  } state_e;

  // One window sum on its way to the rounding divider.
  typedef struct packed {
    logic                       valid;
    logic                       eos;
    logic signed [SUM_BITS-1:0] sum;
  } sum_stage_t;

endpackage

FILE: hdl/cma_cell.sv
// ----------------------------------------------------------------------------
// Delay line cell
// Holds one sample of the window and hands it to the next cell on a shift.
// ----------------------------------------------------------------------------
module cma_cell (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 shift_i,
  input  logic                                 clear_i,
  input  logic signed [cma_pkg::SAMPLE_BITS-1:0] data_i,
  output logic signed [cma_pkg::SAMPLE_BITS-1:0] data_o
);

  logic signed [cma_pkg::SAMPLE_BITS-1:0] data_q;
  logic signed [cma_pkg::SAMPLE_BITS-1:0] data_d;

  // A clear at the end of a sequence wins over the shift.
  always_comb begin
    data_d = data_q;
    if (clear_i) begin
      data_d = '0;
    end else if (shift_i) begin
      data_d = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

FILE: hdl/cma_round.sv
// ----------------------------------------------------------------------------
// Rounding divider and output register
// Divides each window sum by the window length, rounding to nearest with
// ties away from zero, and holds the result until the consumer takes it.
// ----------------------------------------------------------------------------
module cma_round (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cma_pkg::sum_stage_t                   stage_i,
  output logic                                  adv_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [cma_pkg::SAMPLE_BITS-1:0] average_o,
  output logic                                  end_of_sequence_o
);

  logic                                   mag_valid_q;
  logic                                   mag_eos_q;
  logic                                   mag_neg_q;
  logic [cma_pkg::SUM_BITS-1:0]           mag_q;
  logic [cma_pkg::SUM_BITS-1:0]           sum_u;
  logic [cma_pkg::SUM_BITS-1:0]           mag_d;
  logic [cma_pkg::PROD_BITS-1:0]          prod;
  logic [cma_pkg::SAMPLE_BITS-1:0]        quot;
  logic                                   out_valid_q;
  logic                                   out_eos_q;
  logic signed [cma_pkg::SAMPLE_BITS-1:0] out_avg_q;
  logic signed [cma_pkg::SAMPLE_BITS-1:0] out_avg_d;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv_o = !out_valid_q || !out_stall_i;

  // Magnitude of the sum plus half the window, ready for the truncating divide.
  always_comb begin
    sum_u = stage_i.sum;
    if (stage_i.sum[cma_pkg::SUM_BITS-1]) begin
      mag_d = ~sum_u + 1'b1 + cma_pkg::HALF_WINDOW;
    end else begin
      mag_d = sum_u + cma_pkg::HALF_WINDOW;
    end
  end

  // Quotient by reciprocal multiply, then the sign goes back on.
  always_comb begin
    prod = cma_pkg::PROD_BITS'(mag_q) * cma_pkg::PROD_BITS'(cma_pkg::RECIP);
    quot = prod[cma_pkg::DIV_SHIFT +: cma_pkg::SAMPLE_BITS];
    if (mag_neg_q) begin
      out_avg_d = -$signed(quot);
    end else begin
      out_avg_d = $signed(quot);
    end
  end

  // Control bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv_o) begin
      mag_valid_q <= stage_i.valid;
      out_valid_q <= mag_valid_q;
    end
  end

  // Payload of both stages.
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      mag_eos_q <= stage_i.eos;
      mag_neg_q <= stage_i.sum[cma_pkg::SUM_BITS-1];
      mag_q     <= mag_d;
      out_eos_q <= mag_eos_q;
      out_avg_q <= out_avg_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign average_o         = out_avg_q;
  assign end_of_sequence_o = out_eos_q;

endmodule

FILE: hdl/centered_moving_average.sv
// ----------------------------------------------------------------------------
// Centered moving average
// Boxcar average over a centered window of samples, zero outside a sequence.
// ----------------------------------------------------------------------------
// The filter takes one sample item per cycle while a sequence streams in and
// gives one average item per sample, the item for position i once sample
// i + LEAD has arrived (LEAD is 12 for the 25-sample window). The samples sit
// in a row of delay cells next to a running sum, so each item costs one shift
// and one add. After the item flagged final, the input stalls while LEAD
// zeros are shifted in to produce the outstanding items; the last of them
// carries end_of_sequence, and the line and sum are cleared in the same
// cycle. An accepted item passes the sum stage and the magnitude register to
// reach the output register. While a full output register is
// stalled, the whole pipeline and the input stall with it.
module centered_moving_average (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [cma_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                                   is_final_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [cma_pkg::SAMPLE_BITS-1:0] average_o,
  output logic                                   end_of_sequence_o
);

  cma_pkg::state_e                         state_q, state_d;
  logic [cma_pkg::SEEN_BITS-1:0]           seen_q, seen_d;
  logic [cma_pkg::FLUSH_BITS-1:0]          flush_q, flush_d;
  logic signed [cma_pkg::SUM_BITS-1:0]     sum_q, sum_d, sum_new;
  logic signed [cma_pkg::SAMPLE_BITS-1:0]  push_data;
  logic signed [cma_pkg::SAMPLE_BITS-1:0]  line [cma_pkg::WINDOW];
  logic                                    adv;
  logic                                    accept;
  logic                                    shift;
  logic                                    clear;
  logic                                    emit;
  logic                                    eos;
  logic [cma_pkg::SEEN_BITS:0]             pos_sum;
  cma_pkg::sum_stage_t                     stage_q, stage_d;

  assign accept = in_valid_i && !in_stall_o;

  // Delay line: cell 0 takes the new sample, the last cell holds the oldest.
  for (genvar k = 0; k < cma_pkg::WINDOW; k++) begin : g_cell
    if (k == 0) begin : g_head
      cma_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .clear_i (clear),
        .data_i  (push_data),
        .data_o  (line[k])
      );
    end else begin : g_body
      cma_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (shift),
        .clear_i (clear),
        .data_i  (line[k-1]),
        .data_o  (line[k])
      );
    end
  end

  // Running sum after this cycle's push.
  assign sum_new = sum_q + cma_pkg::SUM_BITS'(push_data)
                 - cma_pkg::SUM_BITS'(line[cma_pkg::WINDOW-1]);

  // Position of the flushed output relative to the first owed one.
  assign pos_sum = (cma_pkg::SEEN_BITS+1)'(seen_q) + (cma_pkg::SEEN_BITS+1)'(flush_q);

  // Sequence control: stream samples, then flush with zeros.
  always_comb begin
    state_d    = state_q;
    seen_d     = seen_q;
    flush_d    = flush_q;
    sum_d      = sum_q;
    in_stall_o = !adv;
    push_data  = sample_i;
    shift      = 1'b0;
    clear      = 1'b0;
    emit       = 1'b0;
    eos        = 1'b0;
    unique case (state_q)
      cma_pkg::ST_RUN: begin
        if (accept) begin
          shift = 1'b1;
          sum_d = sum_new;
          if (seen_q != cma_pkg::SEEN_BITS'(cma_pkg::LEAD + 1)) begin
            seen_d = seen_q + 1'b1;
          end
          emit = (seen_d == cma_pkg::SEEN_BITS'(cma_pkg::LEAD + 1));
          if (is_final_i) begin
            state_d = cma_pkg::ST_FLUSH;
            flush_d = cma_pkg::FLUSH_BITS'(1);
          end
        end
      end
      cma_pkg::ST_FLUSH: begin
        in_stall_o = 1'b1;
        push_data  = '0;
        if (adv) begin
          shift = 1'b1;
          sum_d = sum_new;
          emit  = (pos_sum >= (cma_pkg::SEEN_BITS+1)'(cma_pkg::LEAD + 1));
          if (flush_q == cma_pkg::FLUSH_BITS'(cma_pkg::LEAD)) begin
            eos     = 1'b1;
            clear   = 1'b1;
            sum_d   = '0;
            seen_d  = '0;
            flush_d = '0;
            state_d = cma_pkg::ST_RUN;
          end else begin
            flush_d = flush_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = cma_pkg::ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cma_pkg::ST_RUN;
      seen_q  <= '0;
      flush_q <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      flush_q <= flush_d;
      sum_q   <= sum_d;
    end
  end

  // Sum stage feeding the rounding divider.
  always_comb begin
    stage_d = stage_q;
    if (adv) begin
      stage_d.valid = emit;
      stage_d.eos   = eos;
      stage_d.sum   = sum_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= '0;
    end else begin
      stage_q <= stage_d;
    end
  end

  cma_round u_round (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .stage_i           (stage_q),
    .adv_o             (adv),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .average_o         (average_o),
    .end_of_sequence_o (end_of_sequence_o)
  );

  // The input is held off for the whole flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == cma_pkg::ST_FLUSH) |-> in_stall_o)
    else $error("input taken during flush");

  // The last flush step leaves the sum and the sample count cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == cma_pkg::ST_FLUSH && adv &&
       flush_q == cma_pkg::FLUSH_BITS'(cma_pkg::LEAD))
      |=> (sum_q == '0 && seen_q == '0 && state_q == cma_pkg::ST_RUN))
    else $error("state not cleared after flush");

  // The sample count saturates one past the lead.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      seen_q <= cma_pkg::SEEN_BITS'(cma_pkg::LEAD + 1))
    else $error("sample count overran");

  // An end-of-sequence sum only comes out of the flush.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (stage_q.valid && stage_q.eos && !$stable(stage_q))
      |-> $past(state_q == cma_pkg::ST_FLUSH))
    else $error("end of sequence outside flush");

  // Once the sample count has saturated, each accepted item emits a sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (accept && seen_q == cma_pkg::SEEN_BITS'(cma_pkg::LEAD + 1)) |=> stage_q.valid)
    else $error("owed result not emitted");

endmodule
